// File: sv/spq_pkg.sv
package spq_pkg;

   // Default store size and field widths
   localparam int DEPTH_DEF = 16;
   localparam int VALUE_W   = 32;
   localparam int PRI_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;

   // Operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // Contents of one cell
   typedef struct packed {
      logic             valid;
      logic [PRI_W-1:0] pri;
      logic [VALUE_W-1:0] val;
   } slot_type;

   // Operation broadcast to every cell
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [PRI_W-1:0] pri;
      logic [VALUE_W-1:0] val;
   } cell_ctl_type;

   // Compare flags reported by a cell
   typedef struct packed {
      logic after_new;   // new entry belongs at or before this cell
      logic at_or_past;  // cell priority is at or above the delete key
      logic hit;         // cell priority equals the delete key
   } cell_flag_type;

endpackage

// File: sv/spq_if.sv
interface spq_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic signed [spq_pkg::VALUE_W-1:0] value;
   logic [spq_pkg::PRI_W-1:0]         priority_req;

   modport source (output valid, output func, output value, output priority_req,
                   input ready);
   modport sink   (input valid, input func, input value, input priority_req,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [spq_pkg::STATUS_W-1:0]       status;
   logic signed [spq_pkg::VALUE_W-1:0] removed_value;
   logic [spq_pkg::OCC_W-1:0]          occupancy;

   modport source (output valid, output status, output removed_value, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input occupancy,
                   output ready);
endinterface

// File: sv/sorted_priority_queue.sv
// Sorted priority queue built from a row of compare-and-shift cells.
// Requests arrive on req_ch: func selects insert or delete, value is the word
// to store and priority_req the key (lower is nearer the front). Each request
// gives exactly one response on rsp_ch with status, removed_value and the
// occupancy after the operation.
// An insert lands behind every entry of equal or smaller priority, so equal
// priorities leave in arrival order; a delete takes the frontmost entry whose
// priority equals the key. Every cell compares the key in parallel and shifts
// toward its neighbor in the same cycle.
// The response is registered and shows in the cycle after the request is
// accepted. Throughput: one request per cycle while responses are taken;
// the limit is the key compare plus the hit reduction across DEPTH cells.
// Reset empties the queue and drops any pending response; no clearing pass.
// When the receiver stalls, the held response keeps req_ch.ready low, so at
// most one response is ever pending.
module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   spq_pkg::cell_ctl_type  ctl;
   spq_pkg::slot_type      slots [DEPTH];
   spq_pkg::cell_flag_type flags [DEPTH];
   logic [DEPTH-1:0]       after_vec;
   logic [DEPTH-1:0]       hit_vec;
   logic [DEPTH-1:0]       front_hit;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [spq_pkg::VALUE_W-1:0]  removed_ff, removed_in;
   logic [spq_pkg::OCC_W-1:0]    occ_ff, occ_in;

   logic accept;
   logic full;
   logic empty;
   logic found;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CNT_W'(DEPTH));
   assign empty        = (count_ff == '0);
   assign found        = |hit_vec;

   // Broadcast operation
   always_comb begin
      ctl.pri = req_ch.priority_req;
      ctl.val = req_ch.value;
      ctl.ins = accept && (req_ch.func == spq_pkg::FUNC_INSERT) && !full;
      ctl.del = accept && (req_ch.func == spq_pkg::FUNC_DELETE) && found;
   end

   // Cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::slot_type left_s;
      spq_pkg::slot_type right_s;
      logic              left_a;

      if (i == 0) begin : g_head
         assign left_s = '0;
         assign left_a = 1'b0;
      end else begin : g_mid
         assign left_s = slots[i-1];
         assign left_a = after_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_s = '0;
      end else begin : g_body
         assign right_s = slots[i+1];
      end

      spq_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (ctl),
         .left_slot      (left_s),
         .left_after_new (left_a),
         .right_slot     (right_s),
         .slot           (slots[i]),
         .flag           (flags[i])
      );

      assign after_vec[i] = flags[i].after_new;
      assign hit_vec[i]   = flags[i].hit;

      // Equal keys sit together, so the front hit has no hit to its left
      if (i == 0) begin : g_fh0
         assign front_hit[i] = hit_vec[i];
      end else begin : g_fhn
         assign front_hit[i] = hit_vec[i] && !hit_vec[i-1];
      end
   end

   // Pick the removed word from the front hit
   always_comb begin
      removed_in = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (front_hit[k]) begin
            removed_in = removed_in | slots[k].val;
         end
      end
      if (!ctl.del) begin
         removed_in = '0;
      end
   end

   // Status and count
   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::ST_OK;
      if (req_ch.func == spq_pkg::FUNC_INSERT) begin
         if (full) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else if (!found) begin
            status_in = spq_pkg::ST_NOT_FOUND;
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      occ_in = spq_pkg::OCC_W'(count_in);
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         occ_ff     <= occ_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.removed_value = removed_ff;
   assign rsp_ch.occupancy     = occ_ff;

endmodule

// File: sv/spq_cell.sv
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::slot_type     left_slot,
   input  logic                  left_after_new,
   input  spq_pkg::slot_type     right_slot,
   output spq_pkg::slot_type     slot,
   output spq_pkg::cell_flag_type flag
);

   logic                      valid_ff, valid_in;
   logic [spq_pkg::PRI_W-1:0]   pri_ff, pri_in;
   logic [spq_pkg::VALUE_W-1:0] val_ff, val_in;

   // Compares against the broadcast key
   always_comb begin
      flag.after_new  = !valid_ff || (ctl.pri < pri_ff);
      flag.at_or_past = valid_ff && (pri_ff >= ctl.pri);
      flag.hit        = valid_ff && (pri_ff == ctl.pri);
   end

   // Insert shifts right from the slot point, delete shifts left from the hit
   always_comb begin
      valid_in = valid_ff;
      pri_in   = pri_ff;
      val_in   = val_ff;
      if (ctl.ins && flag.after_new) begin
         if (left_after_new) begin
            valid_in = left_slot.valid;
            pri_in   = left_slot.pri;
            val_in   = left_slot.val;
         end else begin
            valid_in = 1'b1;
            pri_in   = ctl.pri;
            val_in   = ctl.val;
         end
      end else if (ctl.del && flag.at_or_past) begin
         valid_in = right_slot.valid;
         pri_in   = right_slot.pri;
         val_in   = right_slot.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pri_ff <= pri_in;
      val_ff <= val_in;
   end

   assign slot.valid = valid_ff;
   assign slot.pri   = pri_ff;
   assign slot.val   = val_ff;

endmodule
